[src/cau_pkg.sv]
package cau_pkg;

  // Operation codes carried in the cmd field.
  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_MUL  = 3'd1,
    CMD_DIV  = 3'd2,
    CMD_CONJ = 3'd3,
    CMD_MAG  = 3'd4
  } cmd_e;

  // Status codes of a result word.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  // Number of quotient bits, one per divider stage.
  localparam int unsigned DivSteps = 32;

  // Input word.
  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } in_t;

  // Result word.
  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    status_e            status;
  } out_t;

  // A finished result that does not need the divider.
  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        ovf;
  } pre_t;

  // Front end output: sign and magnitude of both result parts.
  typedef struct packed {
    cmd_e        cmd;
    logic        neg_re;
    logic        neg_im;
    logic [63:0] mag_re;
    logic [63:0] mag_im;
    logic [63:0] den;
    pre_t        pre;
  } s4_t;

  // Divider stage contents; work holds the remaining dividend bits and the quotient.
  typedef struct packed {
    logic        is_div;
    logic        dz;
    logic [63:0] den;
    logic [63:0] rem_re;
    logic [63:0] rem_im;
    logic [31:0] work_re;
    logic [31:0] work_im;
    logic        neg_re;
    logic        neg_im;
    logic        big_re;
    logic        big_im;
    pre_t        fin;
  } dv_t;

endpackage

[src/cau_chan_if.sv]
interface cau_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/cau_front.sv]
module cau_front import cau_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  in_t  data_i,
  output logic valid_o,
  output s4_t  data_o
);

  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  neg;  // a_re, a_im, b_re, b_im
    logic [31:0] m_ar;
    logic [31:0] m_ai;
    logic [31:0] m_br;
    logic [31:0] m_bi;
    pre_t        pre;
  } s1_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  pneg;
    logic [63:0] p0;
    logic [63:0] p1;
    logic [63:0] p2;
    logic [63:0] p3;
    logic [63:0] p4;
    logic [63:0] p5;
    pre_t        pre;
  } s2_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [65:0] sre;
    logic [65:0] sim;
    logic [63:0] den;
    pre_t        pre;
  } s3_t;

  function automatic logic [31:0] abs32(input logic [31:0] x);
    return x[31] ? (32'd0 - x) : x;
  endfunction

  // Clamp a 33-bit two's complement sum to 32 bits; MSB of the result flags overflow.
  function automatic logic [32:0] sat33(input logic [32:0] s);
    logic [32:0] r;
    if (s[32] != s[31]) begin
      r = {1'b1, s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    end else begin
      r = {1'b0, s[31:0]};
    end
    return r;
  endfunction

  function automatic logic [65:0] to_s66(input logic [63:0] m, input logic n);
    return n ? (66'd0 - {2'b00, m}) : {2'b00, m};
  endfunction

  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  s4_t  s4_d, s4_q;
  logic v1_q, v2_q, v3_q, v4_q;

  // Stage 1: operand magnitudes and the add and conjugate results.
  always_comb begin
    logic [32:0] r_re, r_im;
    r_re = sat33({data_i.a_re[31], data_i.a_re} + {data_i.b_re[31], data_i.b_re});
    r_im = sat33({data_i.a_im[31], data_i.a_im} + {data_i.b_im[31], data_i.b_im});
    s1_d.cmd  = data_i.cmd;
    s1_d.neg  = {data_i.a_re[31], data_i.a_im[31], data_i.b_re[31], data_i.b_im[31]};
    s1_d.m_ar = abs32(data_i.a_re);
    s1_d.m_ai = abs32(data_i.a_im);
    s1_d.m_br = abs32(data_i.b_re);
    s1_d.m_bi = abs32(data_i.b_im);
    s1_d.pre  = '0;
    unique case (data_i.cmd)
      CMD_ADD: begin
        s1_d.pre = '{re: r_re[31:0], im: r_im[31:0], ovf: r_re[32] | r_im[32]};
      end
      CMD_CONJ: begin
        r_im = sat33(33'd0 - {data_i.a_im[31], data_i.a_im});
        s1_d.pre = '{re: data_i.a_re, im: r_im[31:0], ovf: r_im[32]};
      end
      default: begin
        s1_d.pre = '0;
      end
    endcase
  end

  // Stage 2: six 32x32 magnitude products; the magnitude command squares a.
  always_comb begin
    logic sar, sai, sbr, sbi;
    logic is_mag;
    {sar, sai, sbr, sbi} = s1_q.neg;
    is_mag   = (s1_q.cmd == CMD_MAG);
    s2_d.cmd = s1_q.cmd;
    s2_d.pre = s1_q.pre;
    s2_d.p0  = {32'd0, s1_q.m_ar} * {32'd0, (is_mag ? s1_q.m_ar : s1_q.m_br)};
    s2_d.p1  = {32'd0, s1_q.m_ai} * {32'd0, (is_mag ? s1_q.m_ai : s1_q.m_bi)};
    s2_d.p2  = {32'd0, s1_q.m_ar} * {32'd0, s1_q.m_bi};
    s2_d.p3  = {32'd0, s1_q.m_ai} * {32'd0, s1_q.m_br};
    s2_d.p4  = {32'd0, s1_q.m_br} * {32'd0, s1_q.m_br};
    s2_d.p5  = {32'd0, s1_q.m_bi} * {32'd0, s1_q.m_bi};
    s2_d.pneg = {is_mag ? 1'b0 : (sar ^ sbr), is_mag ? 1'b0 : (sai ^ sbi),
                 sar ^ sbi, sai ^ sbr};
  end

  // Stage 3: signed sums of products and the divisor.
  always_comb begin
    logic [65:0] q0, q1, q2, q3;
    q0 = to_s66(s2_q.p0, s2_q.pneg[3]);
    q1 = to_s66(s2_q.p1, s2_q.pneg[2]);
    q2 = to_s66(s2_q.p2, s2_q.pneg[1]);
    q3 = to_s66(s2_q.p3, s2_q.pneg[0]);
    s3_d.cmd = s2_q.cmd;
    s3_d.pre = s2_q.pre;
    s3_d.den = s2_q.p4 + s2_q.p5;
    s3_d.sre = (s2_q.cmd == CMD_MUL) ? (q0 - q1) : (q0 + q1);
    s3_d.sim = (s2_q.cmd == CMD_DIV) ? (q3 - q2) : (q2 + q3);
  end

  // Stage 4: back to sign and magnitude.
  always_comb begin
    logic [65:0] a_re, a_im;
    a_re = s3_q.sre[65] ? (66'd0 - s3_q.sre) : s3_q.sre;
    a_im = s3_q.sim[65] ? (66'd0 - s3_q.sim) : s3_q.sim;
    s4_d.cmd    = s3_q.cmd;
    s4_d.pre    = s3_q.pre;
    s4_d.den    = s3_q.den;
    s4_d.neg_re = s3_q.sre[65];
    s4_d.neg_im = s3_q.sim[65];
    s4_d.mag_re = a_re[63:0];
    s4_d.mag_im = a_im[63:0];
  end

  // Valid bits travel with the words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  assign valid_o = v4_q;
  assign data_o  = s4_q;

endmodule

[src/cau_div_step.sv]
module cau_div_step import cau_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  dv_t  data_i,
  output logic valid_o,
  output dv_t  data_o
);

  // One restoring step: shift in the next dividend bit, subtract when it fits.
  function automatic logic [95:0] step(input logic [63:0] rem, input logic [31:0] work,
                                       input logic [63:0] den);
    logic [64:0] t;
    logic [64:0] d;
    logic        ge;
    t  = {rem, work[31]};
    ge = (t >= {1'b0, den});
    d  = t - {1'b0, den};
    return {ge ? d[63:0] : t[63:0], work[30:0], ge};
  endfunction

  dv_t  d_d, d_q;
  logic v_q;

  always_comb begin
    d_d = data_i;
    {d_d.rem_re, d_d.work_re} = step(data_i.rem_re, data_i.work_re, data_i.den);
    {d_d.rem_im, d_d.work_im} = step(data_i.rem_im, data_i.work_im, data_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = d_q;

endmodule

[src/complex_arithmetic_unit.sv]
// Complex arithmetic unit, signed fixed point with FRAC_BITS fractional bits.
// Input channel in_ch_i carries cmd and the operands a and b; output channel
// out_ch_o carries res_re, res_im and status, one result word per input word.
// Commands: add, multiply, divide, conjugate a, squared magnitude of a.
// Results are truncated toward zero and saturated; status tells of saturation
// or of a zero divisor (which gives a zero result).
// The pipeline is 38 register stages deep: four front stages (magnitudes,
// products, sums, back to sign and magnitude), one divider setup stage, 32
// divider stages of one quotient bit each, and the output register. One word
// can be accepted every cycle while the pipeline is not holding.
// The whole pipeline advances together; it holds when the output register is
// full and the receiver is not ready, and in_ch_i.ready then drops. Bubbles in
// the pipeline still move up while the output register is empty.
// Reset clears every valid bit; no result is pending afterwards.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cau_chan_if.sink      in_ch_i,
  cau_chan_if.source    out_ch_o
);

  // Clamp a sign and magnitude value to 32 bits; MSB flags overflow.
  function automatic logic [32:0] sat32(input logic neg, input logic [63:0] mag,
                                        input logic big);
    logic [63:0] lim;
    logic        ovf;
    logic [31:0] v;
    lim = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
    ovf = big || (mag > lim);
    v   = ovf ? lim[31:0] : mag[31:0];
    if (neg) begin
      v = 32'd0 - v;
    end
    return {ovf, v};
  endfunction

  logic en;
  logic fv;
  s4_t  fd;
  dv_t  s5_d, s5_q;
  logic v5_q;
  dv_t  dv [DivSteps+1];
  logic dvv [DivSteps+1];
  out_t out_d, out_q;
  logic out_v_q;

  // Global advance: the output register is free or being emptied.
  assign en            = !out_v_q || out_ch_o.ready;
  assign in_ch_i.ready = en;

  cau_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_ch_i.valid),
    .data_i  (in_ch_i.data),
    .valid_o (fv),
    .data_o  (fd)
  );

  // Stage 5: finish the non-dividing commands and set up both divider lanes.
  always_comb begin
    logic [95:0] n_re, n_im;
    logic [32:0] r_re, r_im;
    n_re = {32'd0, fd.mag_re} << FRAC_BITS;
    n_im = {32'd0, fd.mag_im} << FRAC_BITS;
    r_re = sat32(fd.neg_re, fd.mag_re >> FRAC_BITS, 1'b0);
    r_im = sat32(fd.neg_im, fd.mag_im >> FRAC_BITS, 1'b0);
    s5_d.is_div  = (fd.cmd == CMD_DIV);
    s5_d.dz      = (fd.den == 64'd0);
    s5_d.den     = fd.den;
    s5_d.neg_re  = fd.neg_re;
    s5_d.neg_im  = fd.neg_im;
    s5_d.big_re  = (n_re[95:32] >= fd.den);
    s5_d.big_im  = (n_im[95:32] >= fd.den);
    s5_d.rem_re  = s5_d.big_re ? 64'd0 : n_re[95:32];
    s5_d.rem_im  = s5_d.big_im ? 64'd0 : n_im[95:32];
    s5_d.work_re = n_re[31:0];
    s5_d.work_im = n_im[31:0];
    unique case (fd.cmd)
      CMD_ADD, CMD_CONJ: s5_d.fin = fd.pre;
      CMD_MUL:           s5_d.fin = '{re: r_re[31:0], im: r_im[31:0],
                                      ovf: r_re[32] | r_im[32]};
      CMD_MAG:           s5_d.fin = '{re: r_re[31:0], im: 32'd0, ovf: r_re[32]};
      default:           s5_d.fin = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= fv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_q <= s5_d;
    end
  end

  assign dv[0]  = s5_q;
  assign dvv[0] = v5_q;

  // Divider: one quotient bit per stage for both lanes.
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    cau_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dvv[k]),
      .data_i  (dv[k]),
      .valid_o (dvv[k+1]),
      .data_o  (dv[k+1])
    );
  end

  // Output stage: saturate quotients or pass the finished result.
  // A quotient too big for the divider is nonzero, so it keeps its sign.
  always_comb begin
    dv_t         t;
    logic [32:0] q_re, q_im;
    t    = dv[DivSteps];
    q_re = sat32(t.neg_re && ((t.work_re != 32'd0) || t.big_re), {32'd0, t.work_re},
                 t.big_re);
    q_im = sat32(t.neg_im && ((t.work_im != 32'd0) || t.big_im), {32'd0, t.work_im},
                 t.big_im);
    if (t.is_div && t.dz) begin
      out_d = '{res_re: '0, res_im: '0, status: ST_DIV0};
    end else if (t.is_div) begin
      out_d = '{res_re: q_re[31:0], res_im: q_im[31:0],
                status: (q_re[32] | q_im[32]) ? ST_SAT : ST_OK};
    end else begin
      out_d = '{res_re: t.fin.re, res_im: t.fin.im,
                status: t.fin.ovf ? ST_SAT : ST_OK};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dvv[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_ch_o.valid = out_v_q;
  assign out_ch_o.data  = out_q;

`ifndef SYNTH
  // A zero divisor always yields a zero result.
  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_q.status == ST_DIV0) |-> (out_q.res_re == '0) && (out_q.res_im == '0))
    else $error("divide by zero result is not zero");

  // A saturated result has at least one part at a bound.
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_q.status == ST_SAT) |->
      (out_q.res_re == 32'sh7FFF_FFFF) || (out_q.res_re == 32'sh8000_0000) ||
      (out_q.res_im == 32'sh7FFF_FFFF) || (out_q.res_im == 32'sh8000_0000))
    else $error("saturated status without a bound value");

  // Restoring division keeps the remainder below the divisor.
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dvv[DivSteps] && dv[DivSteps].is_div && !dv[DivSteps].dz |->
      (dv[DivSteps].rem_re < dv[DivSteps].den) && (dv[DivSteps].rem_im < dv[DivSteps].den))
    else $error("divider remainder out of range");

  // A stalled pipeline keeps its final stage.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dvv[DivSteps]))
    else $error("pipeline moved during a stall");
`endif

endmodule

[tb/complex_arithmetic_unit_tb.sv]
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  localparam int unsigned FracBits = 16;
  localparam int unsigned Latency = 38;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned RandomWords = 850;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cau_chan_if #(.T(in_t))  in_ch ();
  cau_chan_if #(.T(out_t)) out_ch ();

  complex_arithmetic_unit #(.FRAC_BITS(FracBits)) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Results still owed by the unit, oldest first.
  out_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;

  // Clamp a sign and magnitude value to a 32 bit word; flags saturation.
  function automatic logic [31:0] clamp_word(input bit neg, input logic [127:0] mag,
                                             inout bit ovf);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (mag > lim) begin
      mag = lim;
      ovf = 1'b1;
    end
    return neg ? -mag[31:0] : mag[31:0];
  endfunction

  // Expected result word for one input word of the complex unit.
  function automatic out_t complex_result(input in_t w);
    out_t r;
    bit ovf;
    logic signed [127:0] ar, ai, br, bi, sr, si, den;
    logic [127:0] qr, qi;
    ovf = 1'b0;
    ar = w.a_re;
    ai = w.a_im;
    br = w.b_re;
    bi = w.b_im;
    r = '0;
    r.status = ST_OK;
    case (w.cmd)
      CMD_ADD: begin
        sr = ar + br;
        si = ai + bi;
        r.res_re = clamp_word(sr < 0, sr < 0 ? -sr : sr, ovf);
        r.res_im = clamp_word(si < 0, si < 0 ? -si : si, ovf);
      end
      CMD_MUL: begin
        sr = ar * br - ai * bi;
        si = ar * bi + ai * br;
        r.res_re = clamp_word(sr < 0, (sr < 0 ? -sr : sr) >> FracBits, ovf);
        r.res_im = clamp_word(si < 0, (si < 0 ? -si : si) >> FracBits, ovf);
      end
      CMD_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.status = ST_DIV0;
        end else begin
          sr = ar * br + ai * bi;
          si = ai * br - ar * bi;
          qr = ((sr < 0 ? -sr : sr) << FracBits) / den;
          qi = ((si < 0 ? -si : si) << FracBits) / den;
          r.res_re = clamp_word(sr < 0 && qr != 0, qr, ovf);
          r.res_im = clamp_word(si < 0 && qi != 0, qi, ovf);
        end
      end
      CMD_CONJ: begin
        si = -ai;
        r.res_re = w.a_re;
        r.res_im = clamp_word(si < 0, si < 0 ? -si : si, ovf);
      end
      CMD_MAG: begin
        sr = ar * ar + ai * ai;
        r.res_re = clamp_word(1'b0, sr >> FracBits, ovf);
      end
      default: ;
    endcase
    if (ovf) r.status = ST_SAT;
    return r;
  endfunction

  // Directed stimulus; known marks rows whose result is typed in.
  typedef struct {
    in_t  word;
    bit   known;
    out_t result;
  } row_t;

  localparam logic [31:0] MaxQ = 32'h7FFF_FFFF;
  localparam logic [31:0] MinQ = 32'h8000_0000;
  localparam logic [31:0] OneQ = 32'h0001_0000;

  row_t directed_rows[] = '{
    '{'{CMD_ADD, 0, 0, 0, 0}, 1, '{0, 0, ST_OK}},
    '{'{CMD_ADD, MaxQ, MinQ, OneQ, -OneQ}, 1, '{MaxQ, MinQ, ST_SAT}},
    '{'{CMD_ADD, MaxQ, MinQ, MinQ, MaxQ}, 1, '{-1, -1, ST_OK}},
    '{'{CMD_MUL, OneQ, OneQ, OneQ, -OneQ}, 1, '{2 * OneQ, 0, ST_OK}},
    '{'{CMD_MUL, MaxQ, MaxQ, MaxQ, MaxQ}, 0, '{0, 0, ST_OK}},
    '{'{CMD_MUL, MinQ, MinQ, MinQ, MinQ}, 0, '{0, 0, ST_OK}},
    '{'{CMD_MUL, 32'h3, 32'h5, 32'h7, 32'hFFFF_FFF1}, 0, '{0, 0, ST_OK}},
    '{'{CMD_DIV, OneQ, OneQ, 0, 0}, 1, '{0, 0, ST_DIV0}},
    '{'{CMD_DIV, MaxQ, MinQ, 0, 0}, 1, '{0, 0, ST_DIV0}},
    '{'{CMD_DIV, OneQ, 0, OneQ, 0}, 1, '{OneQ, 0, ST_OK}},
    '{'{CMD_DIV, MaxQ, MaxQ, 32'h1, 0}, 0, '{0, 0, ST_OK}},
    '{'{CMD_DIV, MinQ, MinQ, MinQ, MinQ}, 0, '{0, 0, ST_OK}},
    '{'{CMD_DIV, 32'h1, -32'sd1, MaxQ, MinQ}, 0, '{0, 0, ST_OK}},
    '{'{CMD_DIV, -32'sd3, 32'h7, 32'h5, -32'sd2}, 0, '{0, 0, ST_OK}},
    '{'{CMD_CONJ, MaxQ, MinQ, MaxQ, MaxQ}, 1, '{MaxQ, MaxQ, ST_SAT}},
    '{'{CMD_CONJ, MinQ, MaxQ, 0, 0}, 1, '{MinQ, -MaxQ, ST_OK}},
    '{'{CMD_MAG, OneQ, OneQ, MaxQ, MinQ}, 1, '{2 * OneQ, 0, ST_OK}},
    '{'{CMD_MAG, MinQ, MinQ, 0, 0}, 1, '{MaxQ, 0, ST_SAT}},
    '{'{cmd_e'(3'd5), MaxQ, MaxQ, MaxQ, MaxQ}, 1, '{0, 0, ST_OK}},
    '{'{cmd_e'(3'd6), MinQ, MinQ, MinQ, MinQ}, 1, '{0, 0, ST_OK}},
    '{'{cmd_e'(3'd7), -32'sd1, -32'sd1, -32'sd1, -32'sd1}, 1, '{0, 0, ST_OK}}
  };

  // Random operand: mostly full range, sometimes small or at an extreme.
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 3) == 0 ? MaxQ : ($urandom_range(0, 1) ? MinQ : 32'h0);
      1, 2: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
      3: return $signed($urandom_range(0, 255)) - 32'sd128;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t rand_word();
    in_t w;
    w.cmd = $urandom_range(0, 15) == 0 ? cmd_e'($urandom_range(5, 7))
                                       : cmd_e'($urandom_range(0, 4));
    w.a_re = rand_operand();
    w.a_im = rand_operand();
    w.b_re = rand_operand();
    w.b_im = rand_operand();
    if (w.cmd == CMD_DIV && $urandom_range(0, 19) == 0) begin
      w.b_re = 0;
      w.b_im = 0;
    end
    return w;
  endfunction

  // Offer one word and wait until it is accepted; valid stays high for the
  // next word unless the sender idles first.
  task automatic send_word(input in_t w, input bit known, input out_t result);
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_results.push_back(known ? result : complex_result(w));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Receiver: random stalls at the falling edge, with one long hold-off.
  always @(negedge clk_i) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= $urandom_range(1, 100) > recv_stall_pct;
  end

  // Checker and watchdog at the rising edge.
  always @(posedge clk_i) begin
    out_t exp_word;
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result word with none expected: %h", $time, out_ch.data);
          error_count++;
        end else begin
          exp_word = pending_results.pop_front();
          if (out_ch.data.res_re !== exp_word.res_re) begin
            $display("%0t: res_re expected %h actual %h", $time, exp_word.res_re,
                     out_ch.data.res_re);
            error_count++;
          end
          if (out_ch.data.res_im !== exp_word.res_im) begin
            $display("%0t: res_im expected %h actual %h", $time, exp_word.res_im,
                     out_ch.data.res_im);
            error_count++;
          end
          if (out_ch.data.status !== exp_word.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_word.status,
                     out_ch.data.status);
            error_count++;
          end
        end
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Holds the receiver off for a long stretch while words keep coming.
  task automatic long_hold_off();
    hold_off = 1'b1;
    repeat (3 * Latency) @(negedge clk_i);
    hold_off = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words, back to back.
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].result);
    end
    // Pause until every expected word has come.
    in_ch.valid <= 1'b0;
    wait_drained();

    // Random words over the idling phases.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      fork
        if (phase == 0) long_hold_off();
        for (int n = 0; n < RandomWords / 4; n++) send_word(rand_word(), 1'b0, '0);
      join
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (Latency + 4) @(negedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
